// ===== rtl/core/pidaw_pkg.sv =====
// shared types and constants for the anti-windup pid controller
package pidaw_pkg;

   // default sample width and gain fraction bits
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF    = 8;

   // fixed field widths
   localparam int GAIN_W  = 16;
   localparam int INTEG_W = 32;
   localparam int DRIVE_W = 16;
   localparam int CSR_IDX_W = 3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_LIMIT_LOW  = 3'd3,
      CSR_LIMIT_HIGH = 3'd4,
      CSR_LIMITS_ON  = 3'd5
   } csr_index_type;

endpackage

// ===== rtl/core/pid_controller_antiwindup.sv =====
// pid controller with conditional-integration anti-windup, one stream step per sample
// input register then result register; integral and last error feed back per step
// throughput: one sample per cycle unless rsp_tready stalls the result register
// the four gain products and the output clamp sit between the two registers
// reset: synchronous, active high; clears gains, limits, integral, last error and valids
module pid_controller_antiwindup #(
   parameter int SAMPLE_WIDTH = pidaw_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = pidaw_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample channel
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,  // error_sample
   input  logic                                     req_tuser,  // clear
   // result channel
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [pidaw_pkg::DRIVE_W-1:0]            rsp_tdata,  // drive
   // configuration write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [pidaw_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pidaw_pkg::GAIN_W-1:0]             csr_data
);

   localparam int GAIN_W  = pidaw_pkg::GAIN_W;
   localparam int INTEG_W = pidaw_pkg::INTEG_W;
   localparam int DRIVE_W = pidaw_pkg::DRIVE_W;
   localparam int DIFF_W  = SAMPLE_WIDTH + 1;
   localparam int PD_W    = GAIN_W + SAMPLE_WIDTH + 2;
   localparam int IPROD_W = GAIN_W + INTEG_W;
   localparam int SUM_W   = ((PD_W > IPROD_W) ? PD_W : IPROD_W) + 1;
   localparam int LIM_W   = GAIN_W + FRAC_BITS;
   localparam int CMP_W   = ((PD_W > LIM_W) ? PD_W : LIM_W) + 1;
   localparam int ACC_W   = INTEG_W + 1;

   // configuration registers
   logic signed [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [GAIN_W-1:0] limit_low_ff, limit_high_ff;
   logic                     limits_on_ff;

   // controller state
   logic signed [INTEG_W-1:0]      integral_ff, integral_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_err_ff, prev_err_in;

   // input and result registers
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_err_ff;
   logic                           in_clear_ff;
   logic                           out_valid_ff, out_valid_in;
   logic signed [DRIVE_W-1:0]      drive_ff, drive_in;

   // datapath
   logic                           advance, fire;
   logic signed [DIFF_W-1:0]       diff;
   logic signed [PD_W-1:0]         p_term, d_term, pd;
   logic signed [ACC_W-1:0]        acc;
   logic signed [INTEG_W-1:0]      integ_sat;
   logic                           integ_pos, integ_neg;
   logic signed [CMP_W-1:0]        pd_ext, hi_scaled, lo_scaled;
   logic                           hold, take_new;
   logic signed [IPROD_W-1:0]      i_old, i_new;
   logic signed [SUM_W-1:0]        sum, y, y_hi, y_lo;
   logic signed [DRIVE_W-1:0]      drive_calc;

   // configuration writes, always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_low_ff  <= '0;
         limit_high_ff <= '0;
         limits_on_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pidaw_pkg::CSR_GAIN_P:     gain_p_ff     <= csr_data;
            pidaw_pkg::CSR_GAIN_I:     gain_i_ff     <= csr_data;
            pidaw_pkg::CSR_GAIN_D:     gain_d_ff     <= csr_data;
            pidaw_pkg::CSR_LIMIT_LOW:  limit_low_ff  <= csr_data;
            pidaw_pkg::CSR_LIMIT_HIGH: limit_high_ff <= csr_data;
            pidaw_pkg::CSR_LIMITS_ON:  limits_on_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // handshake: the stage moves when the result register is free or drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = drive_ff;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // proportional plus derivative part
   always_comb begin
      diff   = DIFF_W'(in_err_ff) - DIFF_W'(prev_err_ff);
      p_term = PD_W'(gain_p_ff) * PD_W'(in_err_ff);
      d_term = PD_W'(gain_d_ff) * PD_W'(diff);
      pd     = p_term + d_term;
   end

   // saturating integral candidate and anti-windup check
   always_comb begin
      acc = ACC_W'(integral_ff) + ACC_W'(in_err_ff);
      if (acc[ACC_W-1] != acc[ACC_W-2]) begin
         integ_sat = acc[ACC_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                  : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_sat = acc[INTEG_W-1:0];
      end
      integ_pos = !integ_sat[INTEG_W-1] && (|integ_sat);
      integ_neg = integ_sat[INTEG_W-1];
      pd_ext    = CMP_W'(pd);
      hi_scaled = CMP_W'(limit_high_ff) <<< FRAC_BITS;
      lo_scaled = CMP_W'(limit_low_ff) <<< FRAC_BITS;
      hold      = limits_on_ff && (((pd_ext >= hi_scaled) && integ_pos) ||
                                   ((pd_ext <= lo_scaled) && integ_neg));
      take_new  = (gain_i_ff != '0) && !hold;
   end

   // integral products for both candidates, then the full sum and floor shift
   always_comb begin
      i_old = IPROD_W'(gain_i_ff) * IPROD_W'(integral_ff);
      i_new = IPROD_W'(gain_i_ff) * IPROD_W'(integ_sat);
      sum   = SUM_W'(pd) + (take_new ? SUM_W'(i_new) : SUM_W'(i_old));
      y     = sum >>> FRAC_BITS;
   end

   // output clamp to limits or to the 16-bit range
   always_comb begin
      y_hi = SUM_W'(limit_high_ff);
      y_lo = SUM_W'(limit_low_ff);
      if (limits_on_ff) begin
         priority if (y > y_hi) drive_calc = limit_high_ff;
         else if (y < y_lo)     drive_calc = limit_low_ff;
         else                   drive_calc = y[DRIVE_W-1:0];
      end else begin
         priority if (y > SUM_W'(signed'({1'b0, {(DRIVE_W-1){1'b1}}})))
            drive_calc = {1'b0, {(DRIVE_W-1){1'b1}}};
         else if (y < SUM_W'(signed'({1'b1, {(DRIVE_W-1){1'b0}}})))
            drive_calc = {1'b1, {(DRIVE_W-1){1'b0}}};
         else
            drive_calc = y[DRIVE_W-1:0];
      end
   end

   // next state and result
   always_comb begin
      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      drive_in    = drive_calc;
      if (in_clear_ff) begin
         integral_in = '0;
         prev_err_in = '0;
         drive_in    = '0;
      end else begin
         integral_in = take_new ? integ_sat : integral_ff;
         prev_err_in = in_err_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            integral_ff <= integral_in;
            prev_err_ff <= prev_err_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_err_ff   <= req_tdata[SAMPLE_WIDTH-1:0];
         in_clear_ff <= req_tuser;
      end
      if (fire) begin
         drive_ff <= drive_in;
      end
   end

`ifndef SYNTHESIS
   // a clear transfer yields a zero drive
   assert property (@(posedge clock) disable iff (reset)
      fire && in_clear_ff |=> rsp_tvalid && (rsp_tdata == '0))
      else $error("clear did not give zero drive");

   // with ordered limits enabled the computed drive stays inside them
   assert property (@(posedge clock) disable iff (reset)
      fire && !in_clear_ff && limits_on_ff && (limit_low_ff <= limit_high_ff)
      |-> (drive_in >= limit_low_ff) && (drive_in <= limit_high_ff))
      else $error("drive outside enabled limits");

   // zero integral gain leaves the integral untouched
   assert property (@(posedge clock) disable iff (reset)
      fire && !in_clear_ff && (gain_i_ff == '0) |=> integral_ff == $past(integral_ff))
      else $error("integral changed with zero integral gain");

   // a stalled sample stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_err_ff))
      else $error("stalled sample lost");
`endif

endmodule
